/* hw/rtl/weighted_moving_average_macros.svh */
// Assertion helpers for the weighted moving average block.
`ifndef WEIGHTED_MOVING_AVERAGE_MACROS_SVH
`define WEIGHTED_MOVING_AVERAGE_MACROS_SVH
`ifndef SYNTHESIS
`define WMA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("weighted_moving_average: same-cycle check failed");
`define WMA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("weighted_moving_average: next-cycle check failed");
`else
`define WMA_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define WMA_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

/* hw/rtl/wma_pkg.sv */
`default_nettype none
package wma_pkg;

  localparam int SAMPLE_W = 16;
  localparam int CFG_W    = 7;
  localparam logic [CFG_W-1:0] WINDOW_LENGTH_RESET = 7'd10;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAC,
    ST_DRAIN,
    ST_DIV,
    ST_PUSH
  } wma_state_e;

  // Control from the sequencer to the multiply-accumulate unit.
  typedef struct packed {
    logic clear;
    logic valid;
  } mac_ctrl_t;

  // Status from the serial divider back to the sequencer.
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage
`default_nettype wire

/* hw/rtl/wma_if.sv */
`default_nettype none
interface wma_sample_if;
  logic                                valid;
  logic                                ready;
  logic signed [wma_pkg::SAMPLE_W-1:0] sample;
  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface wma_average_if;
  logic                                valid;
  logic                                ready;
  logic signed [wma_pkg::SAMPLE_W-1:0] average;
  modport source (output valid, output average, input ready);
  modport sink   (input valid, input average, output ready);
endinterface

interface wma_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [wma_pkg::CFG_W-1:0]     window_length;
  modport source (output valid, output window_length, input ready);
  modport sink   (input valid, input window_length, output ready);
endinterface
`default_nettype wire

/* hw/rtl/wma_window_mem.sv */
`default_nettype none
module wma_window_mem #(
  parameter int DEPTH = 64
) (
  input  wire logic                                       clk_i,
  input  wire logic                                       rst_ni,
  input  wire logic                                       we_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic signed [wma_pkg::SAMPLE_W-1:0]        wdata_i,
  input  wire logic                                       re_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic signed [wma_pkg::SAMPLE_W-1:0]             rdata_o
);
  import wma_pkg::*;

  logic signed [SAMPLE_W-1:0] mem_q [DEPTH];
  logic [DEPTH-1:0]           valid_q;
  logic signed [SAMPLE_W-1:0] rdata_q;
  logic                       rvalid_q;

  // Entries never written read as zero, which is the cleared state.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rvalid_q <= 1'b0;
    end else begin
      if (we_i) begin
        valid_q[waddr_i] <= 1'b1;
      end
      if (re_i) begin
        rvalid_q <= valid_q[raddr_i];
      end
    end
  end

  assign rdata_o = rvalid_q ? rdata_q : '0;

endmodule
`default_nettype wire

/* hw/rtl/wma_mac.sv */
`default_nettype none
module wma_mac #(
  parameter int WEIGHT_W = 7,
  parameter int DIV_W    = 12,
  parameter int ACC_W    = 28
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire wma_pkg::mac_ctrl_t                  ctrl_i,
  input  wire logic signed [wma_pkg::SAMPLE_W-1:0] value_i,
  input  wire logic [WEIGHT_W-1:0]                 weight_i,
  output logic signed [ACC_W-1:0]                  acc_o,
  output logic [DIV_W-1:0]                         wsum_o,
  output logic                                     busy_o
);
  import wma_pkg::*;

  localparam int PROD_W = SAMPLE_W + WEIGHT_W + 1;

  logic                     pv_q;
  logic signed [PROD_W-1:0] prod_q;
  logic [WEIGHT_W-1:0]      pw_q;
  logic signed [ACC_W-1:0]  acc_q;
  logic [DIV_W-1:0]         wsum_q;

  // Product register first, then the accumulate, so only one multiplier
  // sits between registers.
  always_ff @(posedge clk_i) begin
    prod_q <= value_i * $signed({1'b0, weight_i});
    pw_q   <= weight_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q   <= 1'b0;
      acc_q  <= '0;
      wsum_q <= '0;
    end else if (ctrl_i.clear) begin
      pv_q   <= 1'b0;
      acc_q  <= '0;
      wsum_q <= '0;
    end else begin
      pv_q <= ctrl_i.valid;
      if (pv_q) begin
        acc_q  <= acc_q + ACC_W'(prod_q);
        wsum_q <= wsum_q + DIV_W'(pw_q);
      end
    end
  end

  assign acc_o  = acc_q;
  assign wsum_o = wsum_q;
  assign busy_o = pv_q;

endmodule
`default_nettype wire

/* hw/rtl/wma_divider.sv */
`default_nettype none
module wma_divider #(
  parameter int DIV_W = 12,
  parameter int ACC_W = 28
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire logic signed [ACC_W-1:0]       dividend_i,
  input  wire logic [DIV_W-1:0]              divisor_i,
  output wma_pkg::div_stat_t                 stat_o,
  output logic signed [wma_pkg::SAMPLE_W-1:0] quotient_o
);
  import wma_pkg::*;

  localparam int CNT_W = $clog2(ACC_W + 1);

  logic             busy_q;
  logic             done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [DIV_W:0]   rem_q;
  logic [ACC_W-1:0] quo_q;
  logic [DIV_W-1:0] dsr_q;
  logic             neg_q;
  logic [DIV_W:0]   rem_sh;
  logic             ge;
  logic [SAMPLE_W-1:0] mag;

  // Restoring division on magnitudes, one quotient bit per cycle.
  assign rem_sh = {rem_q[DIV_W-1:0], quo_q[ACC_W-1]};
  assign ge     = rem_sh >= {1'b0, dsr_q};

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i[ACC_W-1] ? ACC_W'(-dividend_i) : ACC_W'(dividend_i);
      dsr_q <= divisor_i;
      neg_q <= dividend_i[ACC_W-1];
    end else if (busy_q) begin
      rem_q <= ge ? (rem_sh - {1'b0, dsr_q}) : rem_sh;
      quo_q <= {quo_q[ACC_W-2:0], ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(ACC_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // A weighted mean of 16-bit samples always fits in 16 bits.
  assign mag         = quo_q[SAMPLE_W-1:0];
  assign quotient_o  = neg_q ? $signed(-mag) : $signed(mag);
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

endmodule
`default_nettype wire

/* hw/rtl/weighted_moving_average.sv */
// Linear weighted moving average over the last N signed 16-bit samples,
// N taken from the window_length register (0 acts as 1, values above
// MAX_WINDOW act as MAX_WINDOW). Every accepted sample word yields exactly
// one average word: sum of sample times weight, weight 1 for the oldest up
// to N for the newest, divided by N(N+1)/2 and truncated toward zero. The
// window is zero after reset, so the first averages lean toward zero.
// One sample takes a shift-and-accumulate pass over the N positions, one
// at a time because of the single read and write port of the window memory
// and the one shared multiplier, then one step per bit of ACC_W in the
// bit-serial divider (ACC_W = 16 + bits of MAX_WINDOW(MAX_WINDOW+1)/2, 28 by
// default), plus the handoff states. The input is not ready during that
// time; a finished average waits in the output register, so the next
// sample can already be taken while it waits.
// No clearing pass is needed after reset.
`default_nettype none
`include "weighted_moving_average_macros.svh"
module weighted_moving_average #(
  parameter int MAX_WINDOW = 64
) (
  input wire logic     clk_i,
  input wire logic     rst_ni,
  wma_sample_if.sink   sample_i,
  wma_average_if.source average_o,
  wma_cfg_if.sink      cfg_i
);
  import wma_pkg::*;

  localparam int ADDR_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int WEIGHT_W = $clog2(MAX_WINDOW + 1);
  localparam int DIV_W = $clog2(MAX_WINDOW * (MAX_WINDOW + 1) / 2 + 1);
  localparam int ACC_W = SAMPLE_W + DIV_W;

  wma_state_e state_q, state_d;

  logic [CFG_W-1:0]           window_length_q;
  logic signed [SAMPLE_W-1:0] sample_q;
  logic [ADDR_W-1:0]          nm1_q;
  logic [ADDR_W-1:0]          nm1_d;
  logic [ADDR_W-1:0]          idx_q;
  logic                       v1_q;
  logic                       last1_q;
  logic [ADDR_W-1:0]          idx1_q;
  logic                       out_valid_q;
  logic signed [SAMPLE_W-1:0] average_q;

  logic                       accept;
  logic                       issue;
  logic                       last;
  logic                       div_start;
  logic                       load_out;
  logic                       out_free;
  logic                       pipe_empty;
  logic signed [SAMPLE_W-1:0] rd_data;
  logic signed [SAMPLE_W-1:0] value;
  logic [WEIGHT_W-1:0]        weight;
  mac_ctrl_t                  mac_ctrl;
  logic signed [ACC_W-1:0]    acc;
  logic [DIV_W-1:0]           wsum;
  logic                       mac_busy;
  div_stat_t                  div_stat;
  logic signed [SAMPLE_W-1:0] quotient;

  // Configuration: the register is always writable.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_length_q <= WINDOW_LENGTH_RESET;
    end else if (cfg_i.valid) begin
      window_length_q <= cfg_i.window_length;
    end
  end

  // Effective length minus one, the index of the newest position.
  always_comb begin
    if (window_length_q == '0) begin
      nm1_d = '0;
    end else if (int'(window_length_q) > MAX_WINDOW) begin
      nm1_d = ADDR_W'(MAX_WINDOW - 1);
    end else begin
      nm1_d = ADDR_W'(window_length_q - CFG_W'(1));
    end
  end

  assign accept     = sample_i.valid && sample_i.ready;
  assign last       = (idx_q == nm1_q);
  assign pipe_empty = !v1_q && !mac_busy;
  assign out_free   = !out_valid_q || average_o.ready;

  // Sequencer: next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (accept) state_d = ST_MAC;
      ST_MAC:   if (last) state_d = ST_DRAIN;
      ST_DRAIN: if (pipe_empty) state_d = ST_DIV;
      ST_DIV:   if (div_stat.done) state_d = ST_PUSH;
      ST_PUSH:  if (out_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // Sequencer: outputs.
  always_comb begin
    sample_i.ready = 1'b0;
    issue          = 1'b0;
    div_start      = 1'b0;
    load_out       = 1'b0;
    unique case (state_q)
      ST_IDLE:  sample_i.ready = 1'b1;
      ST_MAC:   issue = 1'b1;
      ST_DRAIN: div_start = pipe_empty;
      ST_DIV:   ;
      ST_PUSH:  load_out = out_free;
      default:  ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // The pass walks the window from the oldest position up. At step i it
  // reads position i+1 and, in the following cycle, writes that word back to
  // position i, so each position is read before it is overwritten. The
  // newest position takes the new sample instead of a memory word. The
  // same word feeds the multiply-accumulate with weight i+1.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      sample_q <= sample_i.sample;
      nm1_q    <= nm1_d;
    end
    if (accept) begin
      idx_q <= '0;
    end else if (issue) begin
      idx_q <= idx_q + ADDR_W'(1);
    end
    idx1_q  <= idx_q;
    last1_q <= last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= issue;
    end
  end

  assign value  = last1_q ? sample_q : rd_data;
  assign weight = WEIGHT_W'(idx1_q) + WEIGHT_W'(1);

  wma_window_mem #(
    .DEPTH (MAX_WINDOW)
  ) u_window_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (v1_q),
    .waddr_i (idx1_q),
    .wdata_i (value),
    .re_i    (issue && !last),
    .raddr_i (idx_q + ADDR_W'(1)),
    .rdata_o (rd_data)
  );

  assign mac_ctrl.clear = accept;
  assign mac_ctrl.valid = v1_q;

  // The weight sum accumulated alongside gives the divisor N(N+1)/2.
  wma_mac #(
    .WEIGHT_W (WEIGHT_W),
    .DIV_W    (DIV_W),
    .ACC_W    (ACC_W)
  ) u_mac (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (mac_ctrl),
    .value_i  (value),
    .weight_i (weight),
    .acc_o    (acc),
    .wsum_o   (wsum),
    .busy_o   (mac_busy)
  );

  wma_divider #(
    .DIV_W (DIV_W),
    .ACC_W (ACC_W)
  ) u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (acc),
    .divisor_i  (wsum),
    .stat_o     (div_stat),
    .quotient_o (quotient)
  );

  // Output register decouples the result word from the next sample.
  always_ff @(posedge clk_i) begin
    if (load_out) begin
      average_q <= quotient;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (average_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  assign average_o.valid   = out_valid_q;
  assign average_o.average = average_q;

  // Writes stay inside the active part of the window.
  `WMA_ASSERT_IMP(a_write_in_window, clk_i, rst_ni, v1_q, idx1_q <= nm1_q)
  // The divider starts only once the accumulate pipeline has drained.
  `WMA_ASSERT_IMP(a_div_after_mac, clk_i, rst_ni, div_start, !v1_q && !mac_busy)
  // No sample is taken while the divider is working.
  `WMA_ASSERT_IMP(a_busy_not_ready, clk_i, rst_ni, div_stat.busy, !sample_i.ready)
  // A completed division is pushed out in the following cycles, never lost.
  `WMA_ASSERT_NXT(a_done_to_push, clk_i, rst_ni, div_stat.done, state_q == ST_PUSH)

endmodule
`default_nettype wire

/* dv/tb_weighted_moving_average.sv */
`timescale 1ns / 100ps
// Testbench for the linear weighted moving average block.
//
// A predictor inside the testbench keeps its own copy of the window store and
// of the window_length register. For every sample word accepted at the input,
// it shifts the window, forms the weighted sum and divides by N(N+1)/2 with
// truncation toward zero. The resulting average is queued. Every average word
// accepted at the output is compared with the oldest queued value.
//
// The stimulus starts with a short directed part:
//   - the reset window, including full-scale samples,
//   - degenerate lengths (zero, above the maximum, one),
//   - a shrink and regrow of the window, so that positions kept above the
//     short length come back into the sum.
// Random traffic follows in four idling phases: no idling, an idle sender,
// a stalling receiver, and both together. The register is only written once
// every expected average has arrived and the block has had time to settle.
module tb_weighted_moving_average;
  import wma_pkg::*;

  localparam int WINDOW_DEPTH  = 64;
  localparam int SETTLE_CYCLES = 100;  // Above the block's worst latency.
  localparam int PRINT_LIMIT   = 50;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  localparam sample_t SAMPLE_MAX = 16'sh7fff;
  localparam sample_t SAMPLE_MIN = 16'sh8000;

  logic clk_i;
  logic rst_ni;

  wma_sample_if  sample_if ();
  wma_average_if average_if ();
  wma_cfg_if     cfg_if ();

  weighted_moving_average #(
    .MAX_WINDOW(WINDOW_DEPTH)
  ) u_top (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .sample_i (sample_if),
    .average_o(average_if),
    .cfg_i    (cfg_if)
  );

  // Predictor state: the window store and the register as the block should
  // hold them.
  sample_t          window_hist [WINDOW_DEPTH];
  logic [CFG_W-1:0] window_cfg;
  sample_t          expected_averages [$];
  sample_t          oldest_average;

  int send_idle_pct  = 0;
  int stall_pct      = 0;
  int mismatch_count = 0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // The run is cut off well beyond the slowest correct run.
  initial begin
    #20ms;
    $display("[FAIL] regression broken");
    $finish;
  end

  // The receiver stalls at random, at the rate that the current phase sets.
  always @(posedge clk_i) begin
    average_if.ready <= rst_ni && ($urandom_range(99) >= stall_pct);
  end

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= PRINT_LIMIT) begin
      $display("%0t mismatch: %s", $time, msg);
    end
  endtask

  // Shifts one sample into the predicted window and returns the average that
  // the block must produce for it.
  function automatic sample_t next_average(input sample_t value);
    int     n;
    longint acc;
    longint divisor;
    n = int'(window_cfg);
    if (n == 0) begin
      n = 1;  // A zero length acts as one, so the average is the sample itself.
    end
    if (n > WINDOW_DEPTH) begin
      n = WINDOW_DEPTH;  // Lengths above the store size saturate.
    end
    // Only the first n positions move; the ones above keep their contents.
    for (int i = 0; i + 1 < n; i++) begin
      window_hist[i] = window_hist[i + 1];
    end
    window_hist[n - 1] = value;
    acc = 0;
    for (int i = 0; i < n; i++) begin
      acc += longint'(window_hist[i]) * longint'(i + 1);
    end
    divisor = longint'(n) * longint'(n + 1) / 2;
    // Integer division truncates toward zero, as the block does.
    return sample_t'(acc / divisor);
  endfunction

  // Tracks every handshake: the register write, the sample words going in and
  // the average words coming out.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      window_cfg = WINDOW_LENGTH_RESET;
      foreach (window_hist[i]) begin
        window_hist[i] = '0;
      end
      expected_averages.delete();
    end else begin
      if (cfg_if.valid && cfg_if.ready) begin
        window_cfg = cfg_if.window_length;
      end
      if (sample_if.valid && sample_if.ready) begin
        expected_averages.push_back(next_average(sample_if.sample));
      end
      if (average_if.valid && average_if.ready) begin
        if (expected_averages.size() == 0) begin
          report_mismatch($sformatf("average %0d with no sample pending",
                                    average_if.average));
        end else begin
          oldest_average = expected_averages.pop_front();
          if (average_if.average !== oldest_average) begin
            report_mismatch($sformatf("average got %0d, want %0d",
                                      average_if.average, oldest_average));
          end
        end
      end
    end
  end

  // Sends one sample word. The sender may first go idle for a random number
  // of cycles. If it does not, valid stays high from the previous word.
  task automatic send_sample(input sample_t value);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) begin
      gap++;
    end
    if (gap > 0) begin
      sample_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    sample_if.valid  <= 1'b1;
    sample_if.sample <= value;
    do @(posedge clk_i); while (!sample_if.ready);
  endtask

  // Stops sending and waits until every expected average has arrived. Then it
  // gives the block its worst-case latency to come back to rest.
  task automatic wait_for_drain();
    sample_if.valid <= 1'b0;
    while (expected_averages.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_window_length(input logic [CFG_W-1:0] len);
    wait_for_drain();
    cfg_if.valid         <= 1'b1;
    cfg_if.window_length <= len;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
  endtask

  // Picks a sample in one of several styles. Runs of full-scale values drive
  // the accumulator to its limits. Small values exercise rounding toward zero
  // on both sides.
  function automatic sample_t random_sample(input int mode);
    case (mode)
      0: return sample_t'($urandom_range(16'hffff));
      1: return ($urandom_range(1) != 0) ? SAMPLE_MAX : SAMPLE_MIN;
      2: return sample_t'(int'($urandom_range(32)) - 16);
      default: begin
        case ($urandom_range(3))
          0:       return SAMPLE_MAX;
          1:       return SAMPLE_MIN;
          default: return sample_t'($urandom_range(16'hffff));
        endcase
      end
    endcase
  endfunction

  // The first averages after reset, at the reset length of ten, with the
  // window still mostly zero.
  task automatic test_reset_window();
    send_sample(SAMPLE_MAX);
    send_sample(SAMPLE_MAX);
    send_sample(SAMPLE_MIN);
    send_sample(16'sd0);
    send_sample(-16'sd1);
    send_sample(16'sd1);
  endtask

  // Zero acts as one, values above the maximum saturate, and one passes the
  // sample straight through.
  task automatic test_degenerate_lengths();
    write_window_length(CFG_W'(0));
    send_sample(SAMPLE_MAX);
    send_sample(SAMPLE_MIN);
    send_sample(16'sd12345);
    write_window_length(CFG_W'((1 << CFG_W) - 1));
    send_sample(SAMPLE_MIN);
    send_sample(SAMPLE_MIN);
    send_sample(SAMPLE_MAX);
    write_window_length(CFG_W'(WINDOW_DEPTH + 1));
    send_sample(16'sd1);
    send_sample(-16'sd1);
    write_window_length(CFG_W'(1));
    send_sample(-16'sd2);
    send_sample(SAMPLE_MAX);
  endtask

  // Shrinks the window and grows it back. The upper positions must keep what
  // they held while the window was short.
  task automatic test_length_change();
    write_window_length(CFG_W'(8));
    repeat (4) send_sample(SAMPLE_MIN);
    write_window_length(CFG_W'(3));
    repeat (3) send_sample(SAMPLE_MAX);
    write_window_length(CFG_W'(8));
    repeat (2) send_sample(16'sd0);
  endtask

  // Random segments, each with its own window length and sample style.
  // Most lengths are short. Zero, one, the maximum and values above it
  // recur often enough to matter.
  task automatic test_random_traffic(input int sender_idle, input int receiver_stall,
                                     input int word_count);
    int               sent;
    int               seg;
    int               mode;
    logic [CFG_W-1:0] len;
    send_idle_pct = sender_idle;
    stall_pct     = receiver_stall;
    sent          = 0;
    while (sent < word_count) begin
      case ($urandom_range(9))
        0:       len = CFG_W'(0);
        1:       len = CFG_W'($urandom_range(WINDOW_DEPTH + 1, (1 << CFG_W) - 1));
        2:       len = CFG_W'(WINDOW_DEPTH);
        3:       len = CFG_W'(1);
        default: len = CFG_W'($urandom_range(2, 16));
      endcase
      write_window_length(len);
      seg  = $urandom_range(10, 70);
      mode = $urandom_range(3);
      // The last segment of a phase stops at the phase's word count.
      if (seg > word_count - sent) begin
        seg = word_count - sent;
      end
      repeat (seg) begin
        send_sample(random_sample(mode));
        sent++;
      end
    end
  endtask

  initial begin
    rst_ni               = 1'b0;
    sample_if.valid      = 1'b0;
    sample_if.sample     = '0;
    average_if.ready     = 1'b0;
    cfg_if.valid         = 1'b0;
    cfg_if.window_length = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_window();
    test_degenerate_lengths();
    test_length_change();
    test_random_traffic(0, 0, 312);
    test_random_traffic(73, 0, 312);
    test_random_traffic(0, 73, 312);
    test_random_traffic(30, 30, 312);

    wait_for_drain();
    if (mismatch_count == 0 && expected_averages.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
